// ----- rtl/hvd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the haversine distance block.
package hvd_pkg;

  // Default number of CORDIC stages in each rotator and in the vectoring chain.
  localparam int CORDIC_STAGES_DEF = 24;

  // Width of the CORDIC datapath (x, y and angle) and of the square-root datapath.
  localparam int CW = 34;
  localparam int RW = 62;

  // Number of digit steps in each square root (one result bit per step).
  localparam int ROOT_STEPS = 31;

  typedef logic signed [30:0] lat_t;
  typedef logic signed [31:0] lon_t;
  typedef logic        [30:0] dist_t;
  typedef logic        [31:0] angle_t;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic        [RW-1:0] rval_t;

  // Fractional part of the degree to binary-angle factor (the integer part is one).
  localparam logic signed [31:0] DEG_FRAC = 32'sd829128280;
  // Fractional part of the binary-angle to centimetre factor (the integer part is one).
  localparam logic [31:0] CM_FRAC = 32'd3711067422;

  localparam cval_t QUARTER_TURN = 34'sd1073741824;
  localparam cval_t HALF_TURN    = 34'sd2147483648;
  localparam cval_t CORDIC_START = 34'sd652032874;
  localparam logic [31:0] HALF_CIRC_CM = 32'd2001508680;

  // Arctangent of 2^-i in binary-angle units (2^32 per turn).
  localparam logic [29:0] ATAN [32] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
    30'h00000001, 30'h00000000
  };

  // Q2.30 product, rounded half up by a floor shift.
  function automatic cval_t mulq(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return CW'(p >>> 30);
  endfunction

endpackage

// ----- rtl/hvd_in_if.sv -----
// Input channel carrying one pair of positions per word.
interface hvd_in_if;
  import hvd_pkg::*;

  logic valid;
  logic ready;
  lat_t first_latitude;
  lon_t first_longitude;
  lat_t second_latitude;
  lon_t second_longitude;

  modport source (
    output valid, first_latitude, first_longitude, second_latitude, second_longitude,
    input  ready
  );
  modport sink (
    input  valid, first_latitude, first_longitude, second_latitude, second_longitude,
    output ready
  );
endinterface

// ----- rtl/hvd_out_if.sv -----
// Output channel carrying one distance per word.
interface hvd_out_if;
  import hvd_pkg::*;

  logic  valid;
  logic  ready;
  dist_t distance_cm;

  modport source (output valid, distance_cm, input ready);
  modport sink (input valid, distance_cm, output ready);
endinterface

// ----- rtl/haversine_distance.sv -----
// Top level of the pipelined haversine great-circle distance block.
// Takes one word of two positions per cycle and gives one distance per cycle while the
// output is not stalled; the pipeline depth is set by the two CORDIC chains and the
// 31-step square roots. The whole pipeline stalls only while a finished distance waits
// in the output register. Coordinates out of range wrap modulo one turn, coincident
// points give zero and antipodal points saturate at half the circumference.
module haversine_distance #(
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  hvd_in_if.sink       points,
  hvd_out_if.source    result
);
  import hvd_pkg::*;

  localparam int N     = CORDIC_STAGES;
  localparam int DEPTH = 2 * N + 39;

  logic             adv;
  logic [DEPTH-1:0] vld;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv          = !result.valid || result.ready;
  assign points.ready = adv;

  // Valid flags travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], points.valid};
    end
  end

  // Degree to binary angle: v * (1 + frac / 2^32), rounded and taken modulo one turn.
  function automatic angle_t to_angle(input logic signed [31:0] v);
    logic signed [63:0] p;
    p = v * DEG_FRAC;
    p = p + 64'sd2147483648;
    return angle_t'(v) + p[63:32];
  endfunction

  angle_t lat1, lon1, lat2, lon2;

  always_ff @(posedge clk) begin
    if (adv) begin
      lat1 <= to_angle(32'(points.first_latitude));
      lon1 <= to_angle(points.first_longitude);
      lat2 <= to_angle(32'(points.second_latitude));
      lon2 <= to_angle(points.second_longitude);
    end
  end

  // Fold an angle into the right half-plane, noting when the result must be negated.
  function automatic cval_t fold(input angle_t a, output logic flip);
    cval_t t;
    t    = CW'($signed(a));
    flip = 1'b0;
    if (t > QUARTER_TURN) begin
      t    = t - HALF_TURN;
      flip = 1'b1;
    end else if (t < -QUARTER_TURN) begin
      t    = t + HALF_TURN;
      flip = 1'b1;
    end
    return t;
  endfunction

  cval_t rx [4][N+1];
  cval_t ry [4][N+1];
  cval_t rt [4][N+1];
  logic [3:0] flips [N+1];

  // Half differences and quadrant fold of the four rotator angles; the fold flags
  // ride along the rotation chains.
  always_ff @(posedge clk) begin
    angle_t dlat, dlon;
    logic f0, f1, f2, f3;
    if (adv) begin
      dlat = lat2 - lat1;
      dlon = lon2 - lon1;
      rt[0][0] <= fold(lat1, f0);
      rt[1][0] <= fold(lat2, f1);
      rt[2][0] <= fold({1'b0, dlat[31:1]}, f2);
      rt[3][0] <= fold({1'b0, dlon[31:1]}, f3);
      flips[0] <= {f3, f2, f1, f0};
      for (int s = 0; s < N; s++) begin
        flips[s+1] <= flips[s];
      end
    end
  end

  // Four rotation chains: first latitude, second latitude, half dlat, half dlon.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    // Every rotation starts from the gain-compensated unit vector.
    assign rx[l][0] = CORDIC_START;
    assign ry[l][0] = '0;
    for (genvar s = 0; s < N; s++) begin : g_rot
      hvd_cordic_cell #(.STAGE(s), .VECTOR(1'b0)) u_cell (
        .clk  (clk),
        .adv  (adv),
        .x_in (rx[l][s]),
        .y_in (ry[l][s]),
        .t_in (rt[l][s]),
        .x    (rx[l][s+1]),
        .y    (ry[l][s+1]),
        .t    (rt[l][s+1])
      );
    end
  end

  // Undo the fold on the sines and cosines that are used.
  logic signed [31:0] c1, c2, sl, sn;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= 32'(flips[N][0] ? -rx[0][N] : rx[0][N]);
      c2 <= 32'(flips[N][1] ? -rx[1][N] : rx[1][N]);
      sl <= 32'(flips[N][2] ? -ry[2][N] : ry[2][N]);
      sn <= 32'(flips[N][3] ? -ry[3][N] : ry[3][N]);
    end
  end

  // First products.
  cval_t p_ll, p_cc, p_nn;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ll <= mulq(sl, sl);
      p_cc <= mulq(c1, c2);
      p_nn <= mulq(sn, sn);
    end
  end

  // Second product.
  cval_t q_ll, q_cn;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_ll <= p_ll;
      q_cn <= mulq(32'(p_cc), 32'(p_nn));
    end
  end

  // Haversine term, clamped to [0, 1], and its complement.
  rval_t rem_a [ROOT_STEPS+1];
  rval_t res_a [ROOT_STEPS+1];
  rval_t rem_b [ROOT_STEPS+1];
  rval_t res_b [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    cval_t       hav;
    logic [30:0] a;
    if (adv) begin
      hav = q_ll + q_cn;
      if (hav[CW-1]) begin
        a = '0;
      end else if (hav > QUARTER_TURN) begin
        a = 31'(QUARTER_TURN);
      end else begin
        a = 31'(hav);
      end
      rem_a[0] <= RW'({a, 30'd0});
      rem_b[0] <= RW'({31'(QUARTER_TURN) - a, 30'd0});
      res_a[0] <= '0;
      res_b[0] <= '0;
    end
  end

  // Square roots of a and 1-a, one result bit per cell.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    hvd_root_cell #(.STEP(k)) u_root_a (
      .clk    (clk),
      .adv    (adv),
      .rem_in (rem_a[k]),
      .res_in (res_a[k]),
      .rem    (rem_a[k+1]),
      .res    (res_a[k+1])
    );
    hvd_root_cell #(.STEP(k)) u_root_b (
      .clk    (clk),
      .adv    (adv),
      .rem_in (rem_b[k]),
      .res_in (res_b[k]),
      .rem    (rem_b[k+1]),
      .res    (res_b[k+1])
    );
  end

  // Vectoring chain for atan2(sqrt(a), sqrt(1-a)); the zero flag rides alongside.
  cval_t vx [N+1];
  cval_t vy [N+1];
  cval_t vz [N+1];
  logic [N:0] zf;

  assign vy[0] = $signed({{(CW-31){1'b0}}, res_a[ROOT_STEPS][30:0]});
  assign vx[0] = $signed({{(CW-31){1'b0}}, res_b[ROOT_STEPS][30:0]});
  assign vz[0] = '0;
  assign zf[0] = (res_a[ROOT_STEPS][30:0] == '0);

  for (genvar s = 0; s < N; s++) begin : g_vec
    hvd_cordic_cell #(.STAGE(s), .VECTOR(1'b1)) u_cell (
      .clk  (clk),
      .adv  (adv),
      .x_in (vx[s]),
      .y_in (vy[s]),
      .t_in (vz[s]),
      .x    (vx[s+1]),
      .y    (vy[s+1]),
      .t    (vz[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zf[N:1] <= zf[N-1:0];
    end
  end

  // Clamp the half central angle to a quarter turn.
  logic [30:0] zc;
  logic        zf_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      zf_c <= zf[N];
      if (vz[N][CW-1]) begin
        zc <= '0;
      end else if (vz[N] > QUARTER_TURN) begin
        zc <= 31'(QUARTER_TURN);
      end else begin
        zc <= 31'(vz[N]);
      end
    end
  end

  // Fractional part of the scale to centimetres, rounded.
  logic [30:0] zp;
  logic [31:0] frac_cm;
  logic        zf_p;

  always_ff @(posedge clk) begin
    logic [62:0] prod;
    logic [63:0] rnd;
    if (adv) begin
      prod    = zc * CM_FRAC;
      rnd     = {1'b0, prod} + 64'd2147483648;
      frac_cm <= rnd[63:32];
      zp      <= zc;
      zf_p    <= zf_c;
    end
  end

  // Final sum, zero flag, saturation and output register.
  logic [32:0] sum_cm;
  dist_t       dist_next;

  always_comb begin
    sum_cm = {2'b00, zp} + {1'b0, frac_cm};
    if (zf_p) begin
      dist_next = '0;
    end else if (sum_cm > {1'b0, HALF_CIRC_CM}) begin
      dist_next = 31'(HALF_CIRC_CM);
    end else begin
      dist_next = sum_cm[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.distance_cm <= dist_next;
    end
  end

  // A delivered distance never exceeds half the circumference.
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (32'(result.distance_cm) <= HALF_CIRC_CM))
    else $error("distance above half circumference");

  // A zero haversine root yields a zero distance.
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[DEPTH-1] && zf_p) |=> (result.distance_cm == '0))
    else $error("coincident points gave a nonzero distance");

  // A word appears at the output only when one left the last pipeline stage.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(vld[DEPTH-1]))
    else $error("output word without a pipeline word behind it");

  // While the output is stalled, no new word is taken.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> $stable(vld))
    else $error("pipeline moved during an output stall");
endmodule

// ----- rtl/hvd_cordic_cell.sv -----
// One CORDIC micro-rotation stage, in rotation or vectoring mode.
module hvd_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic          clk,
  input  logic          adv,
  input  hvd_pkg::cval_t x_in,
  input  hvd_pkg::cval_t y_in,
  input  hvd_pkg::cval_t t_in,
  output hvd_pkg::cval_t x,
  output hvd_pkg::cval_t y,
  output hvd_pkg::cval_t t
);
  import hvd_pkg::*;

  localparam cval_t ANG = $signed({{(CW-30){1'b0}}, ATAN[STAGE]});

  cval_t dx, dy, x_next, y_next, t_next;
  logic  pos;

  // Direction from the residual angle, or from the sign of y when vectoring.
  always_comb begin
    dx = y_in >>> STAGE;
    dy = x_in >>> STAGE;
    if (VECTOR) begin
      pos = !y_in[CW-1];
      if (pos) begin
        x_next = x_in + dx;
        y_next = y_in - dy;
        t_next = t_in + ANG;
      end else begin
        x_next = x_in - dx;
        y_next = y_in + dy;
        t_next = t_in - ANG;
      end
    end else begin
      pos = !t_in[CW-1];
      if (pos) begin
        x_next = x_in - dx;
        y_next = y_in + dy;
        t_next = t_in - ANG;
      end else begin
        x_next = x_in + dx;
        y_next = y_in - dy;
        t_next = t_in + ANG;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (adv) begin
      x <= x_next;
      y <= y_next;
      t <= t_next;
    end
  end
endmodule

// ----- rtl/hvd_root_cell.sv -----
// One digit step of a restoring integer square root.
module hvd_root_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          adv,
  input  hvd_pkg::rval_t rem_in,
  input  hvd_pkg::rval_t res_in,
  output hvd_pkg::rval_t rem,
  output hvd_pkg::rval_t res
);
  import hvd_pkg::*;

  localparam rval_t BITV = rval_t'(1) << (2 * (ROOT_STEPS - 1) - 2 * STEP);

  rval_t trial, rem_next, res_next;

  // Subtract the trial value where it fits and set the result bit.
  always_comb begin
    trial = res_in + BITV;
    if (rem_in >= trial) begin
      rem_next = rem_in - trial;
      res_next = (res_in >> 1) + BITV;
    end else begin
      rem_next = rem_in;
      res_next = res_in >> 1;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem <= rem_next;
      res <= res_next;
    end
  end
endmodule

// ----- sim/hvd_checker.sv -----
// Checker that predicts each distance from the accepted positions and compares the results.
module hvd_checker (
  input  logic clk,
  input  logic rst,
  hvd_in_if    pts,
  hvd_out_if   res,
  output int   errors,
  output int   pending
);
  import hvd_pkg::*;

  localparam int STAGES = (CORDIC_STAGES_DEF > 32) ? 32 : CORDIC_STAGES_DEF;

  dist_t expected_distances[$];

  // Degrees times 1e7 to a binary angle, rounded to nearest and wrapped.
  function automatic angle_t to_binary_angle(input logic signed [31:0] v);
    longint     s;
    logic [63:0] p;
    s = v;
    p = 64'(s) * 64'd5124095576 + 64'h80000000;
    return p[63:32];
  endfunction

  // Rotation-mode CORDIC giving sine and cosine in Q2.30.
  function automatic void rotate(input angle_t ang, output longint s, output longint c);
    longint t, x, y, dx, dy;
    bit     flip;
    t = longint'(ang);
    x = 652032874;
    y = 0;
    flip = 0;
    if (t >= 64'sd2147483648) t = t - 64'sd4294967296;
    if (t > 64'sd1073741824) begin
      t = t - 64'sd2147483648;
      flip = 1;
    end else if (t < -64'sd1073741824) begin
      t = t + 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (t >= 0) begin
        x = x - dx; y = y + dy; t = t - longint'(ATAN[i]);
      end else begin
        x = x + dx; y = y - dy; t = t + longint'(ATAN[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  // Digit-by-digit square root of a Q1.30 value.
  function automatic longint q30_root(input longint v);
    logic [63:0] rem, acc, probe;
    rem = 64'(v) << 30;
    acc = 0;
    probe = 64'd1 << 60;
    while (probe != 0) begin
      if (rem >= acc + probe) begin
        rem = rem - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return longint'(acc);
  endfunction

  function automatic dist_t predict_distance(input lat_t la1, input lon_t lo1,
                                             input lat_t la2, input lon_t lo2);
    angle_t      a1, b1, a2, b2, hlat, hlon;
    longint      s1, c1, s2, c2, sl, cl, sn, cn, hav, ra, rb, x, y, z, dx, dy;
    logic [63:0] d;
    a1 = to_binary_angle(32'(la1));
    b1 = to_binary_angle(lo1);
    a2 = to_binary_angle(32'(la2));
    b2 = to_binary_angle(lo2);
    hlat = (a2 - a1) >> 1;
    hlon = (b2 - b1) >> 1;
    rotate(a1, s1, c1);
    rotate(a2, s2, c2);
    rotate(hlat, sl, cl);
    rotate(hlon, sn, cn);
    hav = q30_product(sl, sl) + q30_product(q30_product(c1, c2), q30_product(sn, sn));
    if (hav < 0) hav = 0;
    if (hav > 64'sd1073741824) hav = 64'sd1073741824;
    ra = q30_root(hav);
    rb = q30_root(64'sd1073741824 - hav);
    if (ra == 0) return '0;
    // Vectoring CORDIC for half the central angle.
    y = ra;
    x = rb;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sd1073741824) z = 64'sd1073741824;
    d = (64'(z) * 64'd8006034718 + 64'h80000000) >> 32;
    if (d > 64'd2001508680) d = 64'd2001508680;
    return d[30:0];
  endfunction

  assign pending = expected_distances.size();

  // Record a prediction for every accepted word and compare every delivered one.
  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
    end else begin
      if (pts.valid && pts.ready)
        expected_distances.push_back(predict_distance(pts.first_latitude,
            pts.first_longitude, pts.second_latitude, pts.second_longitude));
      if (res.valid && res.ready) begin
        if (expected_distances.size() == 0) begin
          $error("distance_cm expected none actual %0d", res.distance_cm);
          errors <= errors + 1;
        end else begin
          if (res.distance_cm !== expected_distances[0]) begin
            $error("distance_cm expected %0d actual %0d", expected_distances[0],
                   res.distance_cm);
            errors <= errors + 1;
          end
          void'(expected_distances.pop_front());
        end
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Top of the haversine distance testbench: clock, reset, stimulus and verdict.
module tb_top;
  import hvd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  bit   quiet = 0;
  int   errors, pending;

  hvd_in_if  pts();
  hvd_out_if res();

  haversine_distance dut (.clk(clk), .rst(rst), .points(pts.sink), .result(res.source));

  hvd_checker chk (.clk(clk), .rst(rst), .pts(pts), .res(res),
                   .errors(errors), .pending(pending));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    pts.valid = 0;
    pts.first_latitude = '0;
    pts.first_longitude = '0;
    pts.second_latitude = '0;
    pts.second_longitude = '0;
    res.ready = 0;
  end

  // Receiver stalls in random bursts until the final quiet stretch.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || quiet) begin
      res.ready <= !rst;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      res.ready <= 0;
    end else begin
      res.ready <= 1;
    end
  end

  // Offers one word, with an occasional idle burst first, and waits for its acceptance.
  // Ready is sampled mid-cycle, where it is settled, and the word is taken at the next edge.
  task automatic send_pair(input int la1, input int lo1, input int la2, input int lo2);
    int gap;
    bit taken;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      pts.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pts.valid <= 1;
    pts.first_latitude <= lat_t'(la1);
    pts.first_longitude <= lon_t'(lo1);
    pts.second_latitude <= lat_t'(la2);
    pts.second_longitude <= lon_t'(lo2);
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = pts.ready;
      @(posedge clk);
    end
  endtask

  function automatic lat_t rand_lat();
    return lat_t'(int'($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic lon_t rand_lon();
    return lon_t'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
  endfunction

  initial begin
    lat_t la1, la2;
    lon_t lo1, lo2;
    int   kind;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed words: coincident points, extremes, poles, antipodes and wrapping.
    send_pair(0, 0, 0, 0);
    send_pair(900000000, 0, -900000000, 0);
    send_pair(0, 0, 0, 1800000000);
    send_pair(0, -1800000000, 0, 1800000000);
    send_pair(0, 0, 0, -1800000000);
    send_pair(-900000000, -1800000000, 900000000, 1800000000);
    send_pair(900000000, 1234567, 900000000, -7654321);
    send_pair(0, 0, 0, 1);
    send_pair(0, 0, 1, 0);
    send_pair(123456789, 98765432, 123456789, 98765432);
    // Extreme 31-bit latitudes written as their signed values.
    send_pair(1073741823, 32'sh7FFFFFFF, -1073741824, 32'sh80000000);
    send_pair(-1073741824, 32'sh80000000, 1073741823, 32'sh7FFFFFFF);
    send_pair(-1073741824, 0, 1073741823, 0);
    send_pair(0, 32'sh7FFFFFFF, 0, 0);
    send_pair(450000000, 0, -450000000, 1800000000);
    send_pair(10000000, 200000000, -10000000, -1600000000);
    send_pair(-1, -1, 1, 1);
    send_pair(515000000, -1200000, 407000000, -740000000);
    send_pair(715827882, 32'sh55555555, -715827883, 32'shAAAAAAAA);

    // Random words: wide spread, close pairs, near antipodes and raw bit patterns.
    for (int n = 0; n < 1800; n++) begin
      if (n == 1600) quiet = 1;
      kind = $urandom_range(0, 9);
      la1 = rand_lat();
      lo1 = rand_lon();
      if (kind < 4) begin
        la2 = rand_lat();
        lo2 = rand_lon();
      end else if (kind < 7) begin
        la2 = la1 + lat_t'(int'($urandom_range(0, 2000)) - 1000);
        lo2 = lo1 + lon_t'(int'($urandom_range(0, 2000)) - 1000);
      end else if (kind < 9) begin
        la2 = -la1 + lat_t'(int'($urandom_range(0, 200)) - 100);
        lo2 = lo1 + 32'sd1800000000 + lon_t'(int'($urandom_range(0, 200)) - 100);
      end else begin
        la1 = lat_t'($urandom);
        lo1 = lon_t'($urandom);
        la2 = lat_t'($urandom);
        lo2 = lon_t'($urandom);
      end
      send_pair(int'(la1), int'(lo1), int'(la2), int'(lo2));
    end
    pts.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung pipeline.
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule
